@@ hw/rtl/mtep_pkg.sv @@
package mtep_pkg;

    localparam int TIME_WIDTH_DEF = 32;

    localparam logic [1:0] KIND_CHANNEL = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_SEQNUM  = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_CT = 8'hF7;
    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [7:0] META_END        = 8'h2F;
    localparam logic [7:0] META_SEQNUM     = 8'h00;
    localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
    localparam logic [3:0] HI_NOTE_ON      = 4'h9;
    localparam logic [3:0] HI_PROGRAM      = 4'hC;
    localparam logic [3:0] HI_PRESSURE     = 4'hD;
    localparam logic [3:0] HI_SYSTEM       = 4'hF;

    localparam logic REG_FILE_PPQN   = 1'b0;
    localparam logic REG_TARGET_PPQN = 1'b1;
    localparam logic [15:0] FILE_PPQN_RST   = 16'd96;
    localparam logic [15:0] TARGET_PPQN_RST = 16'd192;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  status;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [1:0]  count;
        logic [15:0] seqv;
        logic        add_one;
    } job_t;

endpackage

@@ hw/rtl/midi_track_event_parser.sv @@
// Track event parser for Standard MIDI File track data.
// Input channel (s_*): one track chunk byte per beat; s_track_start marks the
// first byte of a track and clears all parse state before that byte is used.
// Result channel (m_*): one event beat for a channel event, end of track,
// sequence number or error; most bytes produce no beat.
// Config (APB): 0x0 file_ppqn, 0x4 target_ppqn; write only while idle.
// A byte that completes no event is taken whenever the unit is idle. A byte that completes
// an event starts the shared shift/add unit: a serial multiply of the event time by
// target_ppqn into a TIME_WIDTH+16 bit product, then restoring division by file_ppqn
// (one quotient bit per cycle). The quotient is held in the unit until the output
// register is free, then the event is loaded there; s_ready is low while the unit works.
// A stalled receiver holds the output register; the next byte is still taken,
// and a further event waits in the unit with s_ready low until m_ready.
// Reset (aresetn low, synchronous) clears parse state and time, drops m_valid
// and restores file_ppqn 96 and target_ppqn 192.
module midi_track_event_parser #(
    parameter int TIME_WIDTH = mtep_pkg::TIME_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_track_byte,
    input  logic        s_track_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [31:0] m_event_time,
    output logic [7:0]  m_status_byte,
    output logic [7:0]  m_first_data,
    output logic [7:0]  m_second_data,
    output logic [1:0]  m_data_count,
    output logic [15:0] m_sequence_value
);
    import mtep_pkg::*;

    logic [15:0]           file_ppqn_reg;
    logic [15:0]           target_ppqn_reg;
    logic                  cfg_write;
    logic                  s_take;
    logic                  ev_fire;
    job_t                  ev_job;
    logic [TIME_WIDTH-1:0] ev_time;
    job_t                  job_reg;
    logic                  unit_busy;
    logic                  unit_done;
    logic [31:0]           unit_quot;
    logic                  load;
    logic                  m_valid_reg;
    job_t                  out_reg;
    logic [31:0]           time_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {16'd0, (paddr[2] == REG_TARGET_PPQN) ? target_ppqn_reg : file_ppqn_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_ppqn_reg   <= FILE_PPQN_RST;
            target_ppqn_reg <= TARGET_PPQN_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_FILE_PPQN) begin
                file_ppqn_reg <= pwdata[15:0];
            end else begin
                target_ppqn_reg <= pwdata[15:0];
            end
        end
    end

    assign s_ready = !unit_busy;
    assign s_take  = s_valid && s_ready;

    mtep_parser #(.TIME_WIDTH(TIME_WIDTH)) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_take  (s_take),
        .in_byte  (s_track_byte),
        .in_start (s_track_start),
        .ev_fire  (ev_fire),
        .ev_job   (ev_job),
        .ev_time  (ev_time)
    );

    mtep_scale_unit #(.TIME_WIDTH(TIME_WIDTH)) u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_take && ev_fire),
        .time_in (ev_time),
        .mul_in  (target_ppqn_reg),
        .div_in  (file_ppqn_reg),
        .take    (load),
        .busy    (unit_busy),
        .done    (unit_done),
        .quot    (unit_quot)
    );

    always_ff @(posedge aclk) begin
        if (s_take && ev_fire) begin
            job_reg <= ev_job;
        end
    end

    assign load = unit_done && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (load) begin
            out_reg  <= job_reg;
            time_reg <= unit_quot + {31'd0, job_reg.add_one};
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_event_kind     = out_reg.kind;
    assign m_event_time     = time_reg;
    assign m_status_byte    = out_reg.status;
    assign m_first_data     = out_reg.first;
    assign m_second_data    = out_reg.second;
    assign m_data_count     = out_reg.count;
    assign m_sequence_value = out_reg.seqv;

endmodule

@@ hw/rtl/mtep_scale_unit.sv @@
module mtep_scale_unit #(
    parameter int TIME_WIDTH = mtep_pkg::TIME_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [TIME_WIDTH-1:0] time_in,
    input  logic [15:0]           mul_in,
    input  logic [15:0]           div_in,
    input  logic                  take,
    output logic                  busy,
    output logic                  done,
    output logic [31:0]           quot
);
    import mtep_pkg::*;

    localparam int PW = TIME_WIDTH + 16;
    localparam int CW = $clog2(PW);
    localparam logic [CW-1:0] MUL_LAST = CW'(15);
    localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [TIME_WIDTH-1:0] mcand_reg, mcand_next;
    logic [15:0]           mplier_reg, mplier_next;
    logic [15:0]           divisor_reg, divisor_next;
    logic [15:0]           rem_reg, rem_next;
    logic [PW-1:0]         work_reg, work_next;
    logic [16:0]           shifted;
    logic                  ge;

    assign shifted = {rem_reg, work_reg[PW-1]};
    assign ge      = shifted >= {1'b0, divisor_reg};

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        work_next    = work_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next   = ST_MUL;
                    cnt_next     = '0;
                    mcand_next   = time_in;
                    mplier_next  = mul_in;
                    divisor_next = div_in;
                    rem_next     = '0;
                    work_next    = '0;
                end
            end
            ST_MUL: begin
                work_next   = (work_reg << 1) + (mplier_reg[15] ? PW'(mcand_reg) : '0);
                mplier_next = {mplier_reg[14:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                rem_next  = ge ? 16'(shifted - {1'b0, divisor_reg}) : shifted[15:0];
                work_next = {work_reg[PW-2:0], ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        work_reg    <= work_next;
    end

    assign busy = state_reg != ST_IDLE;
    assign done = state_reg == ST_HOLD;
    assign quot = (divisor_reg == '0) ? '1 : work_reg[31:0];

endmodule

@@ hw/rtl/mtep_parser.sv @@
module mtep_parser #(
    parameter int TIME_WIDTH = mtep_pkg::TIME_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_take,
    input  logic [7:0]            in_byte,
    input  logic                  in_start,
    output logic                  ev_fire,
    output mtep_pkg::job_t        ev_job,
    output logic [TIME_WIDTH-1:0] ev_time
);
    import mtep_pkg::*;

    localparam logic [3:0] PH_DELTA     = 4'd0;
    localparam logic [3:0] PH_STATUS    = 4'd1;
    localparam logic [3:0] PH_DATA1     = 4'd2;
    localparam logic [3:0] PH_DATA2     = 4'd3;
    localparam logic [3:0] PH_ONE       = 4'd4;
    localparam logic [3:0] PH_META_TYPE = 4'd5;
    localparam logic [3:0] PH_META_LEN  = 4'd6;
    localparam logic [3:0] PH_SYSEX_LEN = 4'd7;
    localparam logic [3:0] PH_SKIP      = 4'd8;
    localparam logic [3:0] PH_SEQ_HI    = 4'd9;
    localparam logic [3:0] PH_SEQ_LO    = 4'd10;
    localparam logic [3:0] PH_DONE      = 4'd11;
    localparam logic [3:0] PH_ERROR     = 4'd12;

    logic [3:0]            phase_reg, phase_next;
    logic [7:0]            status_reg, status_next;
    logic [TIME_WIDTH-1:0] time_reg, time_next;
    logic [31:0]           qacc_reg, qacc_next;
    logic                  dzero_reg, dzero_next;
    logic [7:0]            held_reg, held_next;
    logic [7:0]            meta_reg, meta_next;
    logic [31:0]           skip_reg, skip_next;
    logic [7:0]            seqhi_reg, seqhi_next;

    function automatic job_t chan_job(input logic [7:0] st, input logic [7:0] d0,
                                      input logic [7:0] d1, input logic [1:0] cnt);
        job_t j;
        j         = '0;
        j.kind    = KIND_CHANNEL;
        j.status  = st;
        if (cnt == 2'd2 && st[7:4] == HI_NOTE_ON && d1 == 8'd0) begin
            j.status = {HI_NOTE_OFF, st[3:0]};
        end
        j.first   = d0;
        j.second  = d1;
        j.count   = cnt;
        return j;
    endfunction

    function automatic job_t seq_job(input logic [15:0] v);
        job_t j;
        j        = '0;
        j.kind   = KIND_SEQNUM;
        j.status = STATUS_META;
        j.seqv   = v;
        return j;
    endfunction

    always_comb begin
        logic [3:0]            ph;
        logic [7:0]            cur;
        logic [TIME_WIDTH-1:0] t;
        logic [31:0]           q;
        logic [31:0]           q_acc;
        logic [31:0]           skip;
        logic [31:0]           skip_dec;
        logic                  vlast;
        logic                  running;
        logic [7:0]            st;

        ph       = in_start ? PH_DELTA : phase_reg;
        cur      = in_start ? 8'd0 : status_reg;
        t        = in_start ? '0 : time_reg;
        q        = in_start ? 32'd0 : qacc_reg;
        skip     = in_start ? 32'd0 : skip_reg;
        skip_dec = skip - 32'd1;
        q_acc    = {q[24:0], in_byte[6:0]};
        vlast    = !in_byte[7];
        running  = !in_byte[7];
        st       = running ? cur : in_byte;

        phase_next  = ph;
        status_next = cur;
        time_next   = t;
        qacc_next   = q;
        dzero_next  = in_start ? 1'b0 : dzero_reg;
        held_next   = in_start ? 8'd0 : held_reg;
        meta_next   = in_start ? 8'd0 : meta_reg;
        skip_next   = skip;
        seqhi_next  = in_start ? 8'd0 : seqhi_reg;
        ev_fire     = 1'b0;
        ev_job      = '0;

        case (ph)
            PH_DELTA: begin
                qacc_next = q_acc;
                if (vlast) begin
                    dzero_next = q_acc == 32'd0;
                    phase_next = PH_STATUS;
                end
            end
            PH_STATUS: begin
                time_next = t + TIME_WIDTH'(q);
                if (st[7] && st[7:4] != HI_SYSTEM) begin
                    status_next = st;
                    if (st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE) begin
                        if (running) begin
                            ev_fire    = 1'b1;
                            ev_job     = chan_job(st, in_byte, 8'd0, 2'd1);
                            phase_next = PH_DELTA;
                            qacc_next  = '0;
                        end else begin
                            phase_next = PH_ONE;
                        end
                    end else if (running) begin
                        held_next  = in_byte;
                        phase_next = PH_DATA2;
                    end else begin
                        phase_next = PH_DATA1;
                    end
                end else if (st == STATUS_SYSEX || st == STATUS_SYSEX_CT) begin
                    status_next = 8'd0;
                    qacc_next   = '0;
                    phase_next  = PH_SYSEX_LEN;
                end else if (st == STATUS_META) begin
                    status_next = 8'd0;
                    phase_next  = PH_META_TYPE;
                end else begin
                    phase_next    = PH_ERROR;
                    ev_fire       = 1'b1;
                    ev_job.kind   = KIND_ERROR;
                    ev_job.status = st;
                end
            end
            PH_DATA1: begin
                held_next  = in_byte;
                phase_next = PH_DATA2;
            end
            PH_DATA2: begin
                ev_fire    = 1'b1;
                ev_job     = chan_job(cur, held_reg, in_byte, 2'd2);
                phase_next = PH_DELTA;
                qacc_next  = '0;
            end
            PH_ONE: begin
                ev_fire    = 1'b1;
                ev_job     = chan_job(cur, in_byte, 8'd0, 2'd1);
                phase_next = PH_DELTA;
                qacc_next  = '0;
            end
            PH_META_TYPE: begin
                meta_next  = in_byte;
                qacc_next  = '0;
                phase_next = PH_META_LEN;
            end
            PH_META_LEN: begin
                qacc_next = q_acc;
                if (vlast) begin
                    if (meta_reg == META_END) begin
                        phase_next     = PH_DONE;
                        ev_fire        = 1'b1;
                        ev_job.kind    = KIND_END;
                        ev_job.status  = STATUS_META;
                        ev_job.first   = META_END;
                        ev_job.add_one = dzero_reg;
                    end else if (meta_reg == META_SEQNUM && q_acc == 32'd0) begin
                        ev_fire    = 1'b1;
                        ev_job     = seq_job(16'd0);
                        phase_next = PH_DELTA;
                        qacc_next  = '0;
                    end else if (meta_reg == META_SEQNUM) begin
                        skip_next  = q_acc;
                        phase_next = PH_SEQ_HI;
                    end else if (q_acc == 32'd0) begin
                        phase_next = PH_DELTA;
                        qacc_next  = '0;
                    end else begin
                        skip_next  = q_acc;
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SYSEX_LEN: begin
                qacc_next = q_acc;
                if (vlast) begin
                    if (q_acc == 32'd0) begin
                        phase_next = PH_DELTA;
                        qacc_next  = '0;
                    end else begin
                        skip_next  = q_acc;
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0) begin
                    phase_next = PH_DELTA;
                    qacc_next  = '0;
                end
            end
            PH_SEQ_HI: begin
                seqhi_next = in_byte;
                skip_next  = skip_dec;
                if (skip_dec == 32'd0) begin
                    ev_fire    = 1'b1;
                    ev_job     = seq_job({8'd0, in_byte});
                    phase_next = PH_DELTA;
                    qacc_next  = '0;
                end else begin
                    phase_next = PH_SEQ_LO;
                end
            end
            PH_SEQ_LO: begin
                skip_next = skip_dec;
                ev_fire   = 1'b1;
                ev_job    = seq_job({seqhi_reg, in_byte});
                if (skip_dec == 32'd0) begin
                    phase_next = PH_DELTA;
                    qacc_next  = '0;
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            default: begin
            end
        endcase
    end

    assign ev_time = time_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_DELTA;
            status_reg <= '0;
            time_reg   <= '0;
            qacc_reg   <= '0;
            dzero_reg  <= 1'b0;
            held_reg   <= '0;
            meta_reg   <= '0;
            skip_reg   <= '0;
            seqhi_reg  <= '0;
        end else if (in_take) begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            time_reg   <= time_next;
            qacc_reg   <= qacc_next;
            dzero_reg  <= dzero_next;
            held_reg   <= held_next;
            meta_reg   <= meta_next;
            skip_reg   <= skip_next;
            seqhi_reg  <= seqhi_next;
        end
    end

endmodule

@@ hw/rtl/mtep_checker.sv @@
module mtep_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_event_kind,
    input logic [31:0] m_event_time,
    input logic [7:0]  m_status_byte,
    input logic [7:0]  m_first_data,
    input logic [7:0]  m_second_data,
    input logic [1:0]  m_data_count,
    input logic [15:0] m_sequence_value
);
    import mtep_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_time) && $stable(m_event_kind))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    a_channel_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == KIND_CHANNEL |->
            (m_data_count == 2'd1 || m_data_count == 2'd2) && m_sequence_value == 16'd0)
        else $error("channel event with bad data count");

    a_other_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != KIND_CHANNEL |->
            m_data_count == 2'd0 && m_second_data == 8'd0)
        else $error("non-channel event carries channel data");

    a_end_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == KIND_END |->
            m_status_byte == STATUS_META && m_first_data == META_END)
        else $error("end of track event with wrong marks");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_event_kind     (m_event_kind),
    .m_event_time     (m_event_time),
    .m_status_byte    (m_status_byte),
    .m_first_data     (m_first_data),
    .m_second_data    (m_second_data),
    .m_data_count     (m_data_count),
    .m_sequence_value (m_sequence_value)
);

@@ dv/midi_track_event_parser_test.sv @@
module midi_track_event_parser_test;
    import mtep_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 80;

    typedef enum logic [3:0] {
        AWAIT_DELTA,
        AWAIT_STATUS,
        AWAIT_DATA1,
        AWAIT_DATA2,
        AWAIT_ONE,
        AWAIT_META_TYPE,
        AWAIT_META_LEN,
        AWAIT_SYSEX_LEN,
        SKIPPING,
        AWAIT_SEQ_HI,
        AWAIT_SEQ_LO,
        TRACK_DONE,
        TRACK_FAULT
    } parse_phase_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] stamp;
        logic [7:0]  status;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [1:0]  count;
        logic [15:0] seqv;
    } midi_event_t;

    class track_scoreboard;
        logic [15:0]  file_ppqn;
        logic [15:0]  target_ppqn;
        parse_phase_e phase;
        logic [7:0]   run_status;
        logic [7:0]   held_byte;
        logic [7:0]   meta_code;
        logic [7:0]   seq_high;
        logic [31:0]  ticks;
        logic [31:0]  vlq;
        logic [31:0]  skip_left;
        logic         zero_delta;
        midi_event_t  pending_q[$];
        int           errors;
        int           kind_seen[4];

        function new();
            file_ppqn = FILE_PPQN_RST;
            target_ppqn = TARGET_PPQN_RST;
            errors = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
            clear_track();
        endfunction

        function void clear_track();
            phase = AWAIT_DELTA;
            run_status = 0;
            held_byte = 0;
            meta_code = 0;
            seq_high = 0;
            ticks = 0;
            vlq = 0;
            skip_left = 0;
            zero_delta = 0;
        endfunction

        function void write_reg(logic idx, logic [15:0] value);
            if (idx == REG_FILE_PPQN) file_ppqn = value;
            else target_ppqn = value;
        endfunction

        function logic [31:0] scaled_ticks();
            logic [63:0] product;
            if (file_ppqn == 16'd0) return '1;
            product = {32'h0, ticks} * {48'h0, target_ppqn};
            product = product / {48'h0, file_ppqn};
            return product[31:0];
        endfunction

        function void expect_event(logic [1:0] kind, logic [31:0] stamp, logic [7:0] status,
                                   logic [7:0] first, logic [7:0] second, logic [1:0] count,
                                   logic [15:0] seqv);
            midi_event_t ev;
            ev.kind = kind;
            ev.stamp = stamp;
            ev.status = status;
            ev.first = first;
            ev.second = second;
            ev.count = count;
            ev.seqv = seqv;
            pending_q = {pending_q, ev};
        endfunction

        function void to_delta();
            phase = AWAIT_DELTA;
            vlq = 0;
        endfunction

        function bit take_vlq(logic [7:0] b);
            vlq = {vlq[24:0], b[6:0]};
            return !b[7];
        endfunction

        function void channel_event(logic [7:0] first, logic [7:0] second, logic [1:0] count);
            logic [7:0] st;
            st = run_status;
            if (count == 2'd2 && st[7:4] == HI_NOTE_ON && second == 8'h00)
                st = {HI_NOTE_OFF, st[3:0]};
            to_delta();
            expect_event(KIND_CHANNEL, scaled_ticks(), st, first, second, count, 16'h0);
        endfunction

        function void on_status(logic [7:0] b);
            logic       running;
            logic [7:0] st;
            running = !b[7];
            ticks = ticks + vlq;
            st = running ? run_status : b;
            if (st[7] && st[7:4] != HI_SYSTEM) begin
                run_status = st;
                if (st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE) begin
                    if (running) channel_event(b, 8'h00, 2'd1);
                    else phase = AWAIT_ONE;
                end else if (running) begin
                    held_byte = b;
                    phase = AWAIT_DATA2;
                end else begin
                    phase = AWAIT_DATA1;
                end
            end else if (st == STATUS_SYSEX || st == STATUS_SYSEX_CT) begin
                run_status = 0;
                vlq = 0;
                phase = AWAIT_SYSEX_LEN;
            end else if (st == STATUS_META) begin
                run_status = 0;
                phase = AWAIT_META_TYPE;
            end else begin
                phase = TRACK_FAULT;
                expect_event(KIND_ERROR, scaled_ticks(), st, 8'h00, 8'h00, 2'd0, 16'h0);
            end
        endfunction

        function void meta_length_done();
            if (meta_code == META_END) begin
                phase = TRACK_DONE;
                expect_event(KIND_END, scaled_ticks() + zero_delta, STATUS_META, META_END,
                             8'h00, 2'd0, 16'h0);
            end else if (meta_code == META_SEQNUM && vlq == 0) begin
                to_delta();
                expect_event(KIND_SEQNUM, scaled_ticks(), STATUS_META, 8'h00, 8'h00, 2'd0,
                             16'h0);
            end else if (vlq == 0) begin
                to_delta();
            end else begin
                skip_left = vlq;
                phase = (meta_code == META_SEQNUM) ? AWAIT_SEQ_HI : SKIPPING;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic start);
            if (start) clear_track();
            case (phase)
                AWAIT_DELTA: begin
                    if (take_vlq(b)) begin
                        zero_delta = (vlq == 0);
                        phase = AWAIT_STATUS;
                    end
                end
                AWAIT_STATUS: on_status(b);
                AWAIT_DATA1: begin
                    held_byte = b;
                    phase = AWAIT_DATA2;
                end
                AWAIT_DATA2: channel_event(held_byte, b, 2'd2);
                AWAIT_ONE: channel_event(b, 8'h00, 2'd1);
                AWAIT_META_TYPE: begin
                    meta_code = b;
                    vlq = 0;
                    phase = AWAIT_META_LEN;
                end
                AWAIT_META_LEN: begin
                    if (take_vlq(b)) meta_length_done();
                end
                AWAIT_SYSEX_LEN: begin
                    if (take_vlq(b)) begin
                        if (vlq == 0) begin
                            to_delta();
                        end else begin
                            skip_left = vlq;
                            phase = SKIPPING;
                        end
                    end
                end
                SKIPPING: begin
                    skip_left = skip_left - 1;
                    if (skip_left == 0) to_delta();
                end
                AWAIT_SEQ_HI: begin
                    seq_high = b;
                    skip_left = skip_left - 1;
                    if (skip_left == 0) begin
                        to_delta();
                        expect_event(KIND_SEQNUM, scaled_ticks(), STATUS_META, 8'h00, 8'h00,
                                     2'd0, {8'h00, b});
                    end else begin
                        phase = AWAIT_SEQ_LO;
                    end
                end
                AWAIT_SEQ_LO: begin
                    skip_left = skip_left - 1;
                    if (skip_left == 0) to_delta();
                    else phase = SKIPPING;
                    expect_event(KIND_SEQNUM, scaled_ticks(), STATUS_META, 8'h00, 8'h00, 2'd0,
                                 {seq_high, b});
                end
                default: ;
            endcase
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_event(midi_event_t got);
            midi_event_t want;
            if (pending_q.size() == 0) begin
                $error("event beat with nothing pending: kind %0d time 0x%0h",
                       got.kind, got.stamp);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            kind_seen[want.kind]++;
            field_check("event_kind", want.kind, got.kind);
            field_check("event_time", want.stamp, got.stamp);
            field_check("status_byte", want.status, got.status);
            field_check("first_data", want.first, got.first);
            field_check("second_data", want.second, got.second);
            field_check("data_count", want.count, got.count);
            field_check("sequence_value", want.seqv, got.seqv);
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_track_byte = 0;
    logic        s_track_start = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_event_kind;
    logic [31:0] m_event_time;
    logic [7:0]  m_status_byte;
    logic [7:0]  m_first_data;
    logic [7:0]  m_second_data;
    logic [1:0]  m_data_count;
    logic [15:0] m_sequence_value;

    track_scoreboard sb;
    bit  track_head = 0;
    bit  src_calm = 0;
    bit  sink_calm = 0;
    int  sink_hold = 0;
    int  stalled = 0;
    int  bytes_sent = 0;
    int  tracks = 0;
    int  timebases = 0;
    int  reg_errors = 0;

    logic [7:0] demo_track [0:23] = '{
        8'h00, 8'h90, 8'h3C, 8'h64,
        8'h81, 8'h00, 8'h3C, 8'h00,
        8'h00, 8'hC5, 8'h7F,
        8'h00, 8'h10,
        8'h00, 8'hFF, 8'h00, 8'h03, 8'h12, 8'h34, 8'h56,
        8'h00, 8'hFF, 8'h2F, 8'h00
    };

    midi_track_event_parser u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_track_byte     (s_track_byte),
        .s_track_start    (s_track_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_event_time     (m_event_time),
        .m_status_byte    (m_status_byte),
        .m_first_data     (m_first_data),
        .m_second_data    (m_second_data),
        .m_data_count     (m_data_count),
        .m_sequence_value (m_sequence_value)
    );

    always #5 aclk = ~aclk;

    function automatic int idle_len(input int longest);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, longest);
    endfunction

    always @(posedge aclk) begin
        midi_event_t beat;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_track_byte, s_track_start);
            if (m_valid && m_ready) begin
                beat.kind = m_event_kind;
                beat.stamp = m_event_time;
                beat.status = m_status_byte;
                beat.first = m_first_data;
                beat.second = m_second_data;
                beat.count = m_data_count;
                beat.seqv = m_sequence_value;
                sb.check_event(beat);
            end
        end
    end

    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_ready = 0;
            sink_hold--;
        end else begin
            m_ready = 1;
            if (!sink_calm) sink_hold = idle_len(48);
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) stalled = 0;
            else stalled++;
            if (stalled >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // called and returns at a falling edge
    task automatic put(input int value);
        int gap;
        gap = src_calm ? 0 : idle_len(40);
        if (gap > 0) begin
            s_valid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1;
        s_track_byte = value[7:0];
        s_track_start = track_head;
        track_head = 0;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic drain();
        s_valid = 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic reg_access(input logic idx, input logic write, input logic [15:0] value);
        psel = 1;
        penable = 0;
        pwrite = write;
        paddr = {idx, 2'b00};
        pwdata = {16'h0, value};
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (write) begin
            sb.write_reg(idx, value);
        end else if (prdata !== {16'h0, value}) begin
            $error("register %0d readback mismatch: expected 0x%0h, got 0x%0h",
                   idx, value, prdata);
            reg_errors++;
        end
        @(negedge aclk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic set_timebase(input logic [15:0] file_val, input logic [15:0] target_val);
        drain();
        reg_access(REG_FILE_PPQN, 1'b1, file_val);
        reg_access(REG_TARGET_PPQN, 1'b1, target_val);
        reg_access(REG_FILE_PPQN, 1'b0, file_val);
        reg_access(REG_TARGET_PPQN, 1'b0, target_val);
        timebases++;
    endtask

    function automatic int data_byte();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 127);
    endfunction

    task automatic put_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            put(0);
        end else if (r < 75) begin
            put($urandom_range(1, 127));
        end else begin
            repeat (r < 94 ? 1 : $urandom_range(2, 4)) put($urandom_range(128, 255));
            put($urandom_range(0, 127));
        end
    endtask

    task automatic put_len(input int len);
        if ($urandom_range(0, 4) == 0) put(8'h80);
        put(len);
    endtask

    task automatic put_channel_data(input logic [7:0] st, input bit running);
        put(running ? $urandom_range(0, 127) : data_byte());
        if (st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE) begin
            if (st[7:4] == HI_NOTE_ON && $urandom_range(0, 3) == 0) put(0);
            else put(data_byte());
        end
    endtask

    task automatic random_track();
        int         r;
        int         len;
        int         code;
        logic [7:0] chan;
        chan = 0;
        track_head = 1;
        tracks++;
        src_calm = ($urandom_range(0, 4) == 0);
        sink_calm = ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(2, 16)) begin
            put_delta();
            r = $urandom_range(0, 99);
            if (r < 45 || (r < 65 && chan == 0)) begin
                chan = 8'($urandom_range(8'h80, 8'hEF));
                put(chan);
                put_channel_data(chan, 0);
            end else if (r < 65) begin
                put_channel_data(chan, 1);
            end else if (r < 73) begin
                chan = 0;
                put($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_SYSEX_CT);
                len = $urandom_range(0, 5);
                put_len(len);
                repeat (len) put($urandom_range(0, 255));
            end else if (r < 85) begin
                chan = 0;
                put(STATUS_META);
                do code = $urandom_range(0, 255);
                while (code == META_END || code == META_SEQNUM);
                put(code);
                len = $urandom_range(0, 5);
                put_len(len);
                repeat (len) put($urandom_range(0, 255));
            end else if (r < 94) begin
                chan = 0;
                put(STATUS_META);
                put(META_SEQNUM);
                len = $urandom_range(0, 4);
                put_len(len);
                repeat (len) put($urandom_range(0, 255));
            end else if (r < 97) begin
                do code = $urandom_range(8'hF1, 8'hFE);
                while (code == STATUS_SYSEX_CT);
                put(code);
                repeat ($urandom_range(0, 3)) put($urandom_range(0, 255));
                return;
            end else begin
                put($urandom_range(0, 255));
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            put_delta();
            put(STATUS_META);
            put(META_END);
            put(0);
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put($urandom_range(0, 255));
    endtask

    initial begin
        logic [15:0] file_val;
        logic [15:0] target_val;
        sb = new();
        repeat (5) @(negedge aclk);
        aresetn = 1;
        reg_access(REG_FILE_PPQN, 1'b0, FILE_PPQN_RST);
        reg_access(REG_TARGET_PPQN, 1'b0, TARGET_PPQN_RST);

        // note on/off, running status, program change, sequence number, end of track,
        // then a data byte with no status and an undefined system status
        track_head = 1;
        tracks++;
        foreach (demo_track[i]) put(demo_track[i]);
        track_head = 1;
        tracks++;
        put(0);
        put(8'h45);
        track_head = 1;
        tracks++;
        put(0);
        put(8'hF5);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin file_val = 16'd1; target_val = 16'd65535; end
                1: begin file_val = 16'd65535; target_val = 16'd1; end
                2: begin file_val = 16'd65535; target_val = 16'd65535; end
                3: begin file_val = 16'd1; target_val = 16'd1; end
                default: begin
                    file_val = 16'($urandom_range(1, 65535));
                    target_val = 16'($urandom_range(1, 65535));
                end
            endcase
            set_timebase(file_val, target_val);
            while (bytes_sent < 30 + 320 * (p + 1)) begin
                random_track();
                if ($urandom_range(0, 9) == 0) drain();
            end
        end

        s_valid = 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d track bytes in %0d tracks over %0d timebase settings",
                 bytes_sent, tracks, timebases + 1);
        $display("Events checked: %0d channel, %0d end, %0d sequence number, %0d error",
                 sb.kind_seen[KIND_CHANNEL], sb.kind_seen[KIND_END],
                 sb.kind_seen[KIND_SEQNUM], sb.kind_seen[KIND_ERROR]);
        if (sb.errors == 0 && reg_errors == 0 && sb.pending_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_scale_unit.sv
hw/rtl/mtep_parser.sv
hw/rtl/midi_track_event_parser.sv
hw/rtl/mtep_checker.sv
dv/midi_track_event_parser_test.sv
